// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the IMU packet receiver.
// No dependencies; assumes i_clk and the active-low i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define IRC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while in reset
`define IRC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/irc_pkg.sv -----
// Package for the IMU packet receiver: CRC-32 helpers, constants, result type.
// No dependencies.
`timescale 1ns / 1ps

package irc_pkg;

    localparam logic [31:0] CRC32_GEN      = 32'h04C1_1DB7;
    localparam logic [31:0] CRC32_SEED     = 32'hFFFF_FFFF;
    localparam logic [31:0] SYNC_RESET     = 32'hFE81_FF55;
    localparam int          HDR_BYTES      = 4;
    localparam int          OUT_WORDS      = 6;
    localparam int          DATA_WORDS_DEF = 6;

    // One byte of MSB-first CRC-32, no reflection
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] r;
        r = crc ^ {b, 24'h0};
        for (int k = 0; k < 8; k++) begin
            r = r[31] ? ({r[30:0], 1'b0} ^ CRC32_GEN) : {r[30:0], 1'b0};
        end
        return r;
    endfunction

    // Four bytes, most significant byte first
    function automatic logic [31:0] crc32_word(input logic [31:0] crc, input logic [31:0] w);
        logic [31:0] r;
        r = crc32_byte(crc, w[31:24]);
        r = crc32_byte(r, w[23:16]);
        r = crc32_byte(r, w[15:8]);
        r = crc32_byte(r, w[7:0]);
        return r;
    endfunction

    localparam logic [31:0] SYNC_CRC_RESET = crc32_word(CRC32_SEED, SYNC_RESET);

    typedef struct packed {
        logic                             crc_ok;
        logic [7:0]                       status_byte;
        logic [7:0]                       iteration;
        logic signed [15:0]               temperature;
        logic [OUT_WORDS-1:0][31:0]       valid_word;
        logic [31:0]                      good_count;
        logic [31:0]                      bad_count;
    } t_result;

endpackage

// ----- rtl/imu_packet_receiver_crc32.sv -----
// Result path: the last CRC byte is held in the input register, then loads the output register.
// Throughput: one byte per cycle; the input stalls only while a finished result
// waits in the output register and the next byte also closes a packet.
// Per-byte CRC is a single byte-wide XOR update between input and state registers.
// Reset (i_rst_n low, synchronous): hunting, counters and valid words cleared,
// sync word back to 0xFE81FF55.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module imu_packet_receiver_crc32
    import irc_pkg::*;
#(
    parameter int DATA_WORDS = DATA_WORDS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Sync word configuration
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [31:0]  i_cfg_data,
    // Byte input
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
    // Packet results
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [7:0] status_byte, [15:8] iteration, [31:16] temperature,
    // [63:32]..[223:192] valid_word_0..5, [255:224] good_count, [287:256] bad_count
    output logic [287:0] m_axis_tdata,
    output logic [0:0]   m_axis_tuser    // [0] crc_ok
);

    logic [31:0] r_sync;
    logic [31:0] r_sync_crc;
    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_out_vld;
    t_result     r_out;

    logic        adv;
    logic        hunting;
    logic        last;
    logic        match;
    t_result     result;

    // Configuration: always ready, precompute header CRC
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync     <= SYNC_RESET;
            r_sync_crc <= SYNC_CRC_RESET;
        end else if (i_cfg_valid) begin
            r_sync     <= i_cfg_data;
            r_sync_crc <= crc32_word(CRC32_SEED, i_cfg_data);
        end
    end

    // Consume the held byte unless it closes a packet into a busy output
    assign adv           = r_in_vld && (!last || !r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    irc_hunt u_hunt (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (adv && hunting),
        .i_byte      (r_in_byte),
        .i_sync_word (r_sync),
        .o_match     (match)
    );

    irc_frame #(
        .DATA_WORDS (DATA_WORDS)
    ) u_frame (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (adv),
        .i_byte     (r_in_byte),
        .i_match    (match),
        .i_sync_crc (r_sync_crc),
        .o_hunting  (hunting),
        .o_last     (last),
        .o_result   (result)
    );

    // Output register: load on packet end, drop when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv && last) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && last) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid   = r_out_vld;
    assign m_axis_tuser[0] = r_out.crc_ok;
    assign m_axis_tdata    = {r_out.bad_count, r_out.good_count,
                              r_out.valid_word[5], r_out.valid_word[4],
                              r_out.valid_word[3], r_out.valid_word[2],
                              r_out.valid_word[1], r_out.valid_word[0],
                              r_out.temperature, r_out.iteration, r_out.status_byte};

    // A closing byte always leaves a result in the output register
    `IRC_ASSERT_NXT(a_emit_next, adv && last, r_out_vld)
    // Never overwrite a result that is still waiting
    `IRC_ASSERT_IMP(a_no_overwrite, r_out_vld && !m_axis_tready, !(adv && last))
    // A byte that is not consumed stays in the input register
    `IRC_ASSERT_NXT(a_in_hold, r_in_vld && !adv, r_in_vld && $stable(r_in_byte))

endmodule

// ----- rtl/irc_hunt.sv -----
// Sync word hunter: sliding three-byte history plus compare with the sync word.
// Depends on irc_pkg.
`timescale 1ns / 1ps

module irc_hunt
    import irc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,       // byte consumed while hunting
    input  logic [7:0]  i_byte,
    input  logic [31:0] i_sync_word,
    output logic        o_match
);

    logic [23:0] r_win;
    logic [31:0] n_cand;

    // Candidate word: oldest byte most significant
    assign n_cand  = {r_win, i_byte};
    assign o_match = (n_cand == i_sync_word);

    // Shift the byte into the history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= 24'h0;
        end else if (i_step) begin
            r_win <= n_cand[23:0];
        end
    end

endmodule

// ----- rtl/irc_frame.sv -----
// Packet collector: byte position, running CRC, field capture, valid set, counters.
// Depends on irc_pkg for the CRC function and the result type.
`timescale 1ns / 1ps

module irc_frame
    import irc_pkg::*;
#(
    parameter int DATA_WORDS = DATA_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,       // one byte consumed this cycle
    input  logic [7:0]  i_byte,
    input  logic        i_match,      // sync word completes with this byte
    input  logic [31:0] i_sync_crc,   // CRC after the four sync bytes
    output logic        o_hunting,
    output logic        o_last,       // this byte ends a packet
    output t_result     o_result
);

    localparam int DATA_END  = HDR_BYTES + 4 * DATA_WORDS;
    localparam int CRC_COVER = DATA_END + 4;
    localparam int PKT_BYTES = CRC_COVER + 4;
    localparam int POS_W     = $clog2(PKT_BYTES);
    localparam int STG_W     = 32 * DATA_WORDS;

    logic [POS_W-1:0]  r_pos;
    logic [31:0]       r_crc;
    logic [STG_W-1:0]  r_stage;
    logic [STG_W-1:0]  r_valid;
    logic [7:0]        r_status;
    logic [7:0]        r_iter;
    logic [15:0]       r_temp;
    logic [31:0]       r_rcv;
    logic [31:0]       r_good;
    logic [31:0]       r_bad;

    logic [31:0]       n_rcv;
    logic              n_ok;

    assign o_hunting = (r_pos == '0);
    assign o_last    = (r_pos == POS_W'(PKT_BYTES - 1));
    assign n_rcv     = {r_rcv[23:0], i_byte};
    assign n_ok      = (r_crc == n_rcv);

    // Advance through the packet one byte per step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_crc    <= CRC32_SEED;
            r_valid  <= '0;
            r_status <= 8'h0;
            r_iter   <= 8'h0;
            r_temp   <= 16'h0;
            r_rcv    <= 32'h0;
            r_good   <= 32'h0;
            r_bad    <= 32'h0;
        end else if (i_step) begin
            if (o_hunting) begin
                if (i_match) begin
                    r_pos <= POS_W'(HDR_BYTES);
                    r_crc <= i_sync_crc;
                end
            end else begin
                if (r_pos < POS_W'(CRC_COVER)) begin
                    r_crc <= crc32_byte(r_crc, i_byte);
                end
                if (r_pos < POS_W'(DATA_END)) begin
                    r_stage <= {r_stage[STG_W-9:0], i_byte};
                end else if (r_pos == POS_W'(DATA_END)) begin
                    r_status <= i_byte;
                end else if (r_pos == POS_W'(DATA_END + 1)) begin
                    r_iter <= i_byte;
                end else if (r_pos < POS_W'(CRC_COVER)) begin
                    r_temp <= {r_temp[7:0], i_byte};
                end else begin
                    r_rcv <= n_rcv;
                end
                // Close the packet: latch on match, count either way
                if (o_last) begin
                    r_pos <= '0;
                    r_crc <= CRC32_SEED;
                    if (n_ok) begin
                        r_good  <= r_good + 32'd1;
                        r_valid <= r_stage;
                    end else begin
                        r_bad <= r_bad + 32'd1;
                    end
                end else begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end
        end
    end

    // Result as seen after this packet's update
    assign o_result.crc_ok      = n_ok;
    assign o_result.status_byte = r_status;
    assign o_result.iteration   = r_iter;
    assign o_result.temperature = r_temp;
    assign o_result.good_count  = n_ok ? r_good + 32'd1 : r_good;
    assign o_result.bad_count   = n_ok ? r_bad : r_bad + 32'd1;

    // First received word sits in the top of the staging vector
    for (genvar k = 0; k < OUT_WORDS; k++) begin : g_word
        if (k < DATA_WORDS) begin : g_live
            assign o_result.valid_word[k] = n_ok ? r_stage[(DATA_WORDS-1-k)*32 +: 32]
                                                 : r_valid[(DATA_WORDS-1-k)*32 +: 32];
        end else begin : g_zero
            assign o_result.valid_word[k] = 32'h0;
        end
    end

endmodule
